[rtl/tcw_pkg.sv]
// shared constants, types and address helpers for the text console writer
package tcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = ROWS * COLUMNS;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int CHAR_W      = 8;
  localparam int CELL_W      = 16;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 32;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h07;

  typedef enum logic [1:0] {
    CMD_READ,
    CMD_NEWLINE,
    CMD_PUT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              in_range;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cmd_t;

  // logical row to physical row of the ring of rows
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                input logic [ROW_W-1:0] row);
    logic [ROW_W:0] sum;
    sum = {1'b0, top} + {1'b0, row};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

[rtl/tcw_front.sv]
// request intake: decodes each request into a command and holds it for the queue
module tcw_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic                         s_action,
  input  logic [tcw_pkg::IN_DATA_W-1:0] s_data,
  input  logic                         clearing,
  output logic                         q_wvalid,
  input  logic                         q_wready,
  output tcw_pkg::cmd_t                q_wdata
);

  tcw_pkg::cmd_t cmd_in;
  tcw_pkg::cmd_t held;
  logic          held_valid;
  logic          s_fire;

  always_comb begin
    cmd_in.char_code = s_data[7:0];
    cmd_in.row       = s_data[12:8];
    cmd_in.col       = s_data[19:13];
    cmd_in.in_range  = (cmd_in.row < tcw_pkg::ROW_W'(tcw_pkg::ROWS)) &&
                       (cmd_in.col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
    if (s_action) begin
      cmd_in.kind = tcw_pkg::CMD_READ;
    end else if (cmd_in.char_code == tcw_pkg::NEWLINE_CODE) begin
      cmd_in.kind = tcw_pkg::CMD_NEWLINE;
    end else begin
      cmd_in.kind = tcw_pkg::CMD_PUT;
    end
  end

  assign s_ready  = !clearing && (!held_valid || q_wready);
  assign s_fire   = s_valid && s_ready;
  assign q_wvalid = held_valid;
  assign q_wdata  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= s_fire || (held_valid && !q_wready);
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      held <= cmd_in;
    end
  end

endmodule

[rtl/tcw_queue.sv]
// short command queue between intake and execution
module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wvalid,
  output logic          wready,
  input  tcw_pkg::cmd_t wdata,
  output logic          rvalid,
  input  logic          rready,
  output tcw_pkg::cmd_t rdata
);

  tcw_pkg::cmd_t                entries [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]   wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0]   rd_ptr;
  logic [tcw_pkg::QCNT_W-1:0]   count;
  logic                         push;
  logic                         pop;

  assign wready = (count != tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign rvalid = (count != '0);
  assign rdata  = entries[rd_ptr];
  assign push   = wvalid && wready;
  assign pop    = rvalid && rready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tcw_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tcw_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + tcw_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - tcw_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

[rtl/tcw_back.sv]
// command execution: cell memory, cursor, row ring scrolling and result register
module tcw_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [tcw_pkg::CHAR_W-1:0]    cfg_wdata,
  input  logic                          q_rvalid,
  output logic                          q_rready,
  input  tcw_pkg::cmd_t                 q_rdata,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::CHAR_W-1:0]    out_char,
  output logic [tcw_pkg::CHAR_W-1:0]    out_color,
  output logic [tcw_pkg::ROW_W-1:0]     out_row,
  output logic [tcw_pkg::COL_W-1:0]     out_col,
  output logic                          out_scrolled
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDWAIT,
    S_BLANK,
    S_WRITE,
    S_EMIT
  } state_t;

  state_t                          state;
  logic [tcw_pkg::CELL_W-1:0]      mem [tcw_pkg::CELLS];
  logic [tcw_pkg::CELL_W-1:0]      rd_data;
  logic                            rd_en;
  logic [tcw_pkg::ADDR_W-1:0]      rd_addr;
  logic                            wr_en;
  logic [tcw_pkg::ADDR_W-1:0]      wr_addr;
  logic [tcw_pkg::CELL_W-1:0]      wr_data;

  logic [tcw_pkg::CHAR_W-1:0]      text_color;
  logic [tcw_pkg::ADDR_W-1:0]      clr_addr;
  logic [tcw_pkg::ROW_W-1:0]       top;
  logic [tcw_pkg::ROW_W-1:0]       cur_row;
  logic [tcw_pkg::COL_W-1:0]       cur_col;
  logic [tcw_pkg::ROW_W-1:0]       blank_row;
  logic [tcw_pkg::COL_W-1:0]       blank_cnt;
  logic                            put_after;
  logic [tcw_pkg::CHAR_W-1:0]      put_char;
  logic [tcw_pkg::CHAR_W-1:0]      res_char;
  logic [tcw_pkg::CHAR_W-1:0]      res_color;
  logic                            res_scrolled;

  logic                            take;
  logic                            wrap;
  logic [tcw_pkg::ROW_W-1:0]       row1;
  logic                            put_scroll;
  logic                            nl_scroll;
  logic [tcw_pkg::ROW_W-1:0]       top_next;

  assign clearing = (state == S_CLEAR);
  assign q_rready = (state == S_IDLE);
  assign take     = q_rvalid && q_rready;

  always_comb begin
    wrap       = (cur_col >= tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
    row1       = wrap ? cur_row + tcw_pkg::ROW_W'(1) : cur_row;
    put_scroll = (row1 >= tcw_pkg::ROW_W'(tcw_pkg::ROWS));
    nl_scroll  = (cur_row >= tcw_pkg::ROW_W'(tcw_pkg::ROWS));
    top_next   = (top == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) ? '0
                                                              : top + tcw_pkg::ROW_W'(1);
  end

  always_comb begin
    rd_en   = take && (q_rdata.kind == tcw_pkg::CMD_READ) && q_rdata.in_range;
    rd_addr = tcw_pkg::cell_addr(tcw_pkg::phys_row(top, q_rdata.row), q_rdata.col);
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CODE};
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_BLANK: begin
        wr_en   = 1'b1;
        wr_addr = tcw_pkg::cell_addr(blank_row, blank_cnt);
        wr_data = {text_color, tcw_pkg::BLANK_CODE};
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = tcw_pkg::cell_addr(tcw_pkg::phys_row(top, cur_row), cur_col);
        wr_data = {text_color, put_char};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tcw_pkg::RESET_COLOR;
    end else if (cfg_wen) begin
      text_color <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      top       <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) begin
            state <= S_IDLE;
          end
          clr_addr <= clr_addr + tcw_pkg::ADDR_W'(1);
        end
        S_IDLE: begin
          if (take) begin
            res_char     <= '0;
            res_color    <= '0;
            res_scrolled <= 1'b0;
            put_char     <= q_rdata.char_code;
            blank_row    <= top;
            blank_cnt    <= '0;
            unique case (q_rdata.kind)
              tcw_pkg::CMD_READ: begin
                state <= q_rdata.in_range ? S_RDWAIT : S_EMIT;
              end
              tcw_pkg::CMD_NEWLINE: begin
                cur_col <= '0;
                if (nl_scroll) begin
                  top          <= top_next;
                  res_scrolled <= 1'b1;
                  put_after    <= 1'b0;
                  state        <= S_BLANK;
                end else begin
                  cur_row <= cur_row + tcw_pkg::ROW_W'(1);
                  state   <= S_EMIT;
                end
              end
              tcw_pkg::CMD_PUT: begin
                if (put_scroll) begin
                  cur_row      <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
                  cur_col      <= '0;
                  top          <= top_next;
                  res_scrolled <= 1'b1;
                  put_after    <= 1'b1;
                  state        <= S_BLANK;
                end else begin
                  cur_row <= row1;
                  if (wrap) begin
                    cur_col <= '0;
                  end
                  state <= S_WRITE;
                end
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          res_char  <= rd_data[7:0];
          res_color <= rd_data[15:8];
          state     <= S_EMIT;
        end
        S_BLANK: begin
          blank_cnt <= blank_cnt + tcw_pkg::COL_W'(1);
          if (blank_cnt == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) begin
            state <= put_after ? S_WRITE : S_EMIT;
          end
        end
        S_WRITE: begin
          cur_col <= cur_col + tcw_pkg::COL_W'(1);
          state   <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            out_char     <= res_char;
            out_color    <= res_color;
            out_row      <= cur_row;
            out_col      <= cur_col;
            out_scrolled <= res_scrolled;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/text_console_char_writer_unit.sv]
// top level of the text console writer: intake, command queue and execution
//
// channel   direction  fields (lowest bit first)
// s_axis    in         tuser: action; tdata: char_code, read_row, read_col
// m_axis    out        tdata: cell_char, cell_color, cursor_row, cursor_col, scrolled
// cfg       in         cfg_wdata: text_color
//
// the execution sequencer takes a read through rdwait, a put through write, a newline straight to emit
// an out-of-range read skips the memory and goes straight to emit; intake and queue each register a request
// a scroll first blanks the new bottom row, one blanked cell per cycle on the single write port
// after reset a clearing pass writes all 2000 cells, and no requests are taken until it ends
// the 4-entry queue keeps taking requests until it is full while a result waits on m_axis
module text_console_char_writer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tcw_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // char_code, read_row, read_col
  input  logic                            s_axis_tuser,  // action
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // cell_char, cell_color,
                                                         // cursor_row, cursor_col, scrolled
  input  logic                            cfg_wen,
  input  logic [tcw_pkg::CHAR_W-1:0]      cfg_wdata
);

  tcw_pkg::cmd_t                q_wdata;
  tcw_pkg::cmd_t                q_rdata;
  logic                         q_wvalid;
  logic                         q_wready;
  logic                         q_rvalid;
  logic                         q_rready;
  logic                         clearing;
  logic [tcw_pkg::CHAR_W-1:0]   out_char;
  logic [tcw_pkg::CHAR_W-1:0]   out_color;
  logic [tcw_pkg::ROW_W-1:0]    out_row;
  logic [tcw_pkg::COL_W-1:0]    out_col;
  logic                         out_scrolled;

  tcw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_action (s_axis_tuser),
    .s_data   (s_axis_tdata),
    .clearing (clearing),
    .q_wvalid (q_wvalid),
    .q_wready (q_wready),
    .q_wdata  (q_wdata)
  );

  tcw_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wvalid (q_wvalid),
    .wready (q_wready),
    .wdata  (q_wdata),
    .rvalid (q_rvalid),
    .rready (q_rready),
    .rdata  (q_rdata)
  );

  tcw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .q_rvalid     (q_rvalid),
    .q_rready     (q_rready),
    .q_rdata      (q_rdata),
    .clearing     (clearing),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_char     (out_char),
    .out_color    (out_color),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_scrolled (out_scrolled)
  );

  assign m_axis_tdata = {3'b000, out_scrolled, out_col, out_row, out_color, out_char};

endmodule

[tb/sv/console_tb_pkg.sv]
// request and reply layouts and the action code shared by the console bench
`timescale 1ns / 100ps
package console_tb_pkg;

  typedef enum logic {
    ACT_PUT  = 1'b0,
    ACT_READ = 1'b1
  } console_action_t;

  // s_axis tdata, lowest bits first: char_code, read_row, read_col
  typedef struct packed {
    logic [tcw_pkg::COL_W-1:0]  read_col;
    logic [tcw_pkg::ROW_W-1:0]  read_row;
    logic [tcw_pkg::CHAR_W-1:0] char_code;
  } console_request_t;

  // m_axis tdata, lowest bits first: cell_char, cell_color, cursor_row, cursor_col, scrolled
  typedef struct packed {
    logic                       scrolled;
    logic [tcw_pkg::COL_W-1:0]  cursor_col;
    logic [tcw_pkg::ROW_W-1:0]  cursor_row;
    logic [tcw_pkg::CHAR_W-1:0] cell_color;
    logic [tcw_pkg::CHAR_W-1:0] cell_char;
  } console_report_t;

endpackage

[tb/sv/text_console_checker.sv]
// checker that tracks the console screen and cursor and compares every reply
`timescale 1ns / 100ps
module text_console_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [tcw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_wen,
  input  logic [tcw_pkg::CHAR_W-1:0]     cfg_wdata,
  output int                             error_count,
  output int                             reports_owed
);

  logic [tcw_pkg::CELL_W-1:0]    screen [tcw_pkg::CELLS];
  int                            row_pos;
  int                            col_pos;
  logic [tcw_pkg::CHAR_W-1:0]    color;
  console_tb_pkg::console_report_t pending_reports [$];

  function automatic void scroll_screen();
    for (int i = 0; i < (tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS; i++) begin
      screen[i] = screen[i + tcw_pkg::COLUMNS];
    end
    for (int i = (tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS; i < tcw_pkg::CELLS; i++) begin
      screen[i] = {color, tcw_pkg::BLANK_CODE};
    end
  endfunction

  function automatic console_tb_pkg::console_report_t console_step(
      input console_tb_pkg::console_action_t act,
      input console_tb_pkg::console_request_t req);
    console_tb_pkg::console_report_t rep;
    rep = '0;
    if (act == console_tb_pkg::ACT_READ) begin
      if (int'(req.read_row) < tcw_pkg::ROWS && int'(req.read_col) < tcw_pkg::COLUMNS) begin
        {rep.cell_color, rep.cell_char} =
          screen[int'(req.read_row) * tcw_pkg::COLUMNS + int'(req.read_col)];
      end
    end else if (req.char_code == tcw_pkg::NEWLINE_CODE) begin
      col_pos = 0;
      // newline with the row already pending past the bottom scrolls at once
      if (row_pos >= tcw_pkg::ROWS) begin
        scroll_screen();
        rep.scrolled = 1'b1;
      end else begin
        row_pos++;
      end
    end else begin
      if (col_pos >= tcw_pkg::COLUMNS) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= tcw_pkg::ROWS) begin
        scroll_screen();
        rep.scrolled = 1'b1;
        col_pos = 0;
        row_pos = tcw_pkg::ROWS - 1;
      end
      screen[row_pos * tcw_pkg::COLUMNS + col_pos] = {color, req.char_code};
      col_pos++;
    end
    rep.cursor_row = tcw_pkg::ROW_W'(row_pos);
    rep.cursor_col = tcw_pkg::COL_W'(col_pos);
    return rep;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    console_tb_pkg::console_report_t want;
    console_tb_pkg::console_report_t got;
    if (rst) begin
      for (int i = 0; i < tcw_pkg::CELLS; i++) begin
        screen[i] = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CODE};
      end
      row_pos = 0;
      col_pos = 0;
      color = tcw_pkg::RESET_COLOR;
      pending_reports.delete();
      error_count = 0;
    end else begin
      if (cfg_wen) begin
        color = cfg_wdata;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_reports.push_back(console_step(
          console_tb_pkg::console_action_t'(s_axis_tuser),
          console_tb_pkg::console_request_t'(
            s_axis_tdata[$bits(console_tb_pkg::console_request_t)-1:0])));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = console_tb_pkg::console_report_t'(
          m_axis_tdata[$bits(console_tb_pkg::console_report_t)-1:0]);
        if (pending_reports.size() == 0) begin
          $error("reply with no request outstanding: tdata %h", m_axis_tdata);
          error_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("cell_char", want.cell_char, got.cell_char);
          check_field("cell_color", want.cell_color, got.cell_color);
          check_field("cursor_row", want.cursor_row, got.cursor_row);
          check_field("cursor_col", want.cursor_col, got.cursor_col);
          check_field("scrolled", want.scrolled, got.scrolled);
        end
      end
    end
    reports_owed = pending_reports.size();
  end

endmodule

[tb/sv/tb_top.sv]
// bench top for the text console writer: clock, reset, requests, config and verdict
`timescale 1ns / 100ps
module tb_top;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int TOTAL_REQUESTS = 1100;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [tcw_pkg::IN_DATA_W-1:0]  s_axis_tdata;  // char_code, read_row, read_col
  logic                           s_axis_tuser;  // action
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // cell_char, cell_color, cursor_row, cursor_col, scrolled
  logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_wen = 1'b0;
  logic [tcw_pkg::CHAR_W-1:0]     cfg_wdata = '0;
  int                             error_count;
  int                             reports_owed;

  console_tb_pkg::console_request_t req_fields = '0;
  console_tb_pkg::console_action_t  req_action = console_tb_pkg::ACT_PUT;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               hold_requests = 0;
  int               holds_served = 0;
  int               hold_left = 0;
  int               requests_sent = 0;
  int               cycle_count = 0;

  assign s_axis_tdata = tcw_pkg::IN_DATA_W'(req_fields);
  assign s_axis_tuser = req_action;

  text_console_char_writer_unit uut (.*);

  text_console_checker chk (.*);

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // reply side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(input console_tb_pkg::console_action_t act,
                              input logic [tcw_pkg::CHAR_W-1:0] code,
                              input logic [tcw_pkg::ROW_W-1:0] row,
                              input logic [tcw_pkg::COL_W-1:0] col);
    req_action <= act;
    req_fields <= '{read_col: col, read_row: row, char_code: code};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    requests_sent++;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic put_char(input logic [tcw_pkg::CHAR_W-1:0] code);
    send_request(console_tb_pkg::ACT_PUT, code, tcw_pkg::ROW_W'($urandom),
                 tcw_pkg::COL_W'($urandom));
  endtask

  task automatic read_cell(input logic [tcw_pkg::ROW_W-1:0] row,
                           input logic [tcw_pkg::COL_W-1:0] col);
    send_request(console_tb_pkg::ACT_READ, tcw_pkg::CHAR_W'($urandom), row, col);
  endtask

  task automatic random_read();
    logic [tcw_pkg::ROW_W-1:0] row;
    logic [tcw_pkg::COL_W-1:0] col;
    row = ($urandom_range(9) == 0) ? tcw_pkg::ROW_W'($urandom)
                                   : tcw_pkg::ROW_W'($urandom_range(tcw_pkg::ROWS - 1));
    col = ($urandom_range(9) == 0) ? tcw_pkg::COL_W'($urandom)
                                   : tcw_pkg::COL_W'($urandom_range(tcw_pkg::COLUMNS - 1));
    read_cell(row, col);
  endtask

  // lines of random text with random reads mixed in, some long enough to wrap, ended by one or more newlines
  task automatic random_traffic(input int target);
    int run;
    while (requests_sent < target) begin
      run = ($urandom_range(3) == 0) ? $urandom_range(170, 75) : $urandom_range(40);
      for (int k = 0; k < run && requests_sent < target; k++) begin
        if ($urandom_range(4) == 0) begin
          random_read();
        end else begin
          put_char(tcw_pkg::CHAR_W'($urandom));
        end
      end
      repeat ($urandom_range(3, 1)) put_char(tcw_pkg::NEWLINE_CODE);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (reports_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_color(input logic [tcw_pkg::CHAR_W-1:0] value);
    cfg_wdata <= value;
    cfg_wen <= 1'b1;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // clearing pass after reset
    while (!s_axis_tready) @(negedge clk);

    read_cell('0, '0);
    read_cell(tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1), tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
    read_cell(tcw_pkg::ROW_W'(tcw_pkg::ROWS), '0);
    read_cell('1, '1);
    read_cell('0, tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
    put_char(8'h00);
    put_char(8'hff);
    put_char(8'h41);
    read_cell('0, tcw_pkg::COL_W'(1));
    // walk to the pending row past the bottom, then newline again to scroll
    repeat (tcw_pkg::ROWS + 1) put_char(tcw_pkg::NEWLINE_CODE);
    put_char(8'h7e);
    read_cell(tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1), '0);

    wait_idle();
    write_color(8'h00);
    random_traffic(300);

    wait_idle();
    write_color(8'hff);
    send_idle_pct = 65;
    random_traffic(450);
    wait_idle();
    random_traffic(550);

    wait_idle();
    write_color(tcw_pkg::CHAR_W'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 65;
    hold_requests++;
    repeat (24) put_char(tcw_pkg::CHAR_W'($urandom));
    random_traffic(800);

    wait_idle();
    write_color(8'h1e);
    send_idle_pct = 22;
    recv_stall_pct = 22;
    random_traffic(TOTAL_REQUESTS);

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
